/* hw/rtl/mrdip_pkg.sv */
`default_nettype none
package mrdip_pkg;

  localparam int unsigned BASE_W     = 13;
  localparam int unsigned COUNT_W    = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned VALUE_W    = 64;

  localparam logic [CFG_IDX_W-1:0] REG_DIGIT_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIGIT_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INSERT_POS  = 2'd2;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam int unsigned KIND_W = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_REJECT,
    KIND_LOAD,
    KIND_DRAIN
  } item_kind_e;

endpackage
`default_nettype wire

/* hw/rtl/mrdip_cfg.sv */
`default_nettype none
module mrdip_cfg #(
  parameter int unsigned MAX_ELEMENTS = 4096,
  localparam int unsigned IW = $clog2(MAX_ELEMENTS + 1)
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_valid_i,
  input  wire logic [mrdip_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [mrdip_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output logic                                    restart_o,
  output logic                                    busy_o,
  output logic                                    cfg_ok_o,
  output logic [mrdip_pkg::BASE_W-1:0]            digit_base_o,
  output logic [IW-1:0]                           table_size_o,
  output logic [IW-1:0]                           middle_limit_o,
  output logic [IW-1:0]                           high_stride_o,
  output logic [IW-1:0]                           high_limit_o
);

  localparam int unsigned PW = $clog2(MAX_ELEMENTS + 2);
  localparam int unsigned MW = PW + mrdip_pkg::BASE_W;
  localparam int unsigned CW = mrdip_pkg::COUNT_W;

  logic [mrdip_pkg::BASE_W-1:0] base_q;
  logic [CW-1:0]                count_q;
  logic [CW-1:0]                pos_q;
  logic                         run_q;
  logic [CW-1:0]                exp_q;
  logic [PW-1:0]                pow_q;
  logic                         ok_q;
  logic [IW-1:0]                size_q;
  logic [IW-1:0]                mid_q;
  logic [IW-1:0]                stride_q;
  logic [IW-1:0]                high_q;

  logic                         hit;
  logic [MW-1:0]                prod;
  logic [PW-1:0]                pow_d;
  logic [CW-1:0]                high_exp;
  logic [CW:0]                  stride_exp;

  always_comb begin
    case (cfg_index_i)
      mrdip_pkg::REG_DIGIT_BASE:  hit = cfg_valid_i;
      mrdip_pkg::REG_DIGIT_COUNT: hit = cfg_valid_i;
      mrdip_pkg::REG_INSERT_POS:  hit = cfg_valid_i;
      default:                    hit = 1'b0;
    endcase
  end

  assign prod       = MW'(pow_q) * MW'(base_q);
  assign pow_d      = (prod > MW'(MAX_ELEMENTS)) ? PW'(MAX_ELEMENTS + 1) : prod[PW-1:0];
  assign high_exp   = count_q - pos_q - CW'(1);
  assign stride_exp = (CW + 1)'(pos_q) + (CW + 1)'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= mrdip_pkg::BASE_W'(2);
      count_q  <= CW'(1);
      pos_q    <= '0;
      run_q    <= 1'b0;
      exp_q    <= '0;
      pow_q    <= PW'(1);
      ok_q     <= 1'b1;
      size_q   <= IW'(2);
      mid_q    <= IW'(1);
      stride_q <= IW'(2);
      high_q   <= IW'(1);
    end else if (hit) begin
      case (cfg_index_i)
        mrdip_pkg::REG_DIGIT_BASE:  base_q  <= cfg_data_i[mrdip_pkg::BASE_W-1:0];
        mrdip_pkg::REG_DIGIT_COUNT: count_q <= cfg_data_i[CW-1:0];
        mrdip_pkg::REG_INSERT_POS:  pos_q   <= cfg_data_i[CW-1:0];
        default: ;
      endcase
      run_q <= 1'b1;
      exp_q <= '0;
      pow_q <= PW'(1);
      ok_q  <= 1'b0;
    end else if (run_q) begin
      if (exp_q == pos_q) begin
        mid_q <= pow_q[IW-1:0];
      end
      if ((CW + 1)'(exp_q) == stride_exp) begin
        stride_q <= pow_q[IW-1:0];
      end
      if (exp_q == high_exp) begin
        high_q <= pow_q[IW-1:0];
      end
      if (exp_q == count_q) begin
        size_q <= pow_q[IW-1:0];
        ok_q   <= (base_q != '0) && (count_q != '0) && (pos_q < count_q) &&
                  (pow_q <= PW'(MAX_ELEMENTS));
        run_q  <= 1'b0;
      end else begin
        pow_q <= pow_d;
        exp_q <= exp_q + CW'(1);
      end
    end
  end

  assign restart_o      = hit;
  assign busy_o         = run_q;
  assign cfg_ok_o       = ok_q;
  assign digit_base_o   = base_q;
  assign table_size_o   = size_q;
  assign middle_limit_o = mid_q;
  assign high_stride_o  = stride_q;
  assign high_limit_o   = high_q;

endmodule
`default_nettype wire

/* hw/rtl/mrdip_front.sv */
`default_nettype none
module mrdip_front #(
  parameter int unsigned MAX_ELEMENTS = 4096,
  parameter int unsigned VALUE_BITS   = 64,
  localparam int unsigned IW = $clog2(MAX_ELEMENTS + 1),
  localparam int unsigned AW = $clog2(MAX_ELEMENTS)
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             accept_i,
  input  wire logic                             restart_i,
  input  wire logic                             opcode_i,
  input  wire logic [mrdip_pkg::VALUE_W-1:0]    element_value_i,
  input  wire logic                             cfg_ok_i,
  input  wire logic [mrdip_pkg::BASE_W-1:0]     digit_base_i,
  input  wire logic [IW-1:0]                    table_size_i,
  input  wire logic [IW-1:0]                    middle_limit_i,
  input  wire logic [IW-1:0]                    high_stride_i,
  input  wire logic [IW-1:0]                    high_limit_i,
  output mrdip_pkg::item_kind_e                 kind_o,
  output logic                                  last_o,
  output logic [AW-1:0]                         addr_o,
  output logic [VALUE_BITS-1:0]                 value_o
);

  localparam int unsigned CW = ((IW > mrdip_pkg::BASE_W) ? IW : mrdip_pkg::BASE_W) + 1;

  logic [IW-1:0] low_q, mid_q, high_q, lacc_q, hacc_q;
  logic [IW-1:0] load_idx_q, drain_idx_q;
  logic          full_q;

  logic          load_ok, drain_ok;
  logic [IW:0]   load_next, drain_next;
  logic          load_last, drain_last;
  logic [IW+1:0] addr_sum;
  logic          low_wrap, mid_wrap, high_wrap;

  always_comb begin
    load_ok    = cfg_ok_i && !full_q && (load_idx_q < table_size_i);
    drain_ok   = cfg_ok_i && full_q && (drain_idx_q < table_size_i);
    load_next  = (IW + 1)'(load_idx_q) + (IW + 1)'(1);
    drain_next = (IW + 1)'(drain_idx_q) + (IW + 1)'(1);
    load_last  = (load_next == (IW + 1)'(table_size_i));
    drain_last = (drain_next == (IW + 1)'(table_size_i));
    addr_sum   = (IW + 2)'(mid_q) + (IW + 2)'(hacc_q) + (IW + 2)'(lacc_q);
    low_wrap   = (CW'(low_q) + CW'(1)) >= CW'(digit_base_i);
    mid_wrap   = ((IW + 1)'(mid_q) + (IW + 1)'(1)) >= (IW + 1)'(middle_limit_i);
    high_wrap  = ((IW + 1)'(high_q) + (IW + 1)'(1)) >= (IW + 1)'(high_limit_i);

    if (opcode_i == mrdip_pkg::OP_LOAD) begin
      kind_o = load_ok ? mrdip_pkg::KIND_LOAD : mrdip_pkg::KIND_REJECT;
      last_o = load_ok && load_last;
      addr_o = addr_sum[AW-1:0];
    end else begin
      kind_o = drain_ok ? mrdip_pkg::KIND_DRAIN : mrdip_pkg::KIND_REJECT;
      last_o = drain_ok && drain_last;
      addr_o = drain_idx_q[AW-1:0];
    end
    value_o = element_value_i[VALUE_BITS-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q       <= '0;
      mid_q       <= '0;
      high_q      <= '0;
      lacc_q      <= '0;
      hacc_q      <= '0;
      load_idx_q  <= '0;
      drain_idx_q <= '0;
      full_q      <= 1'b0;
    end else if (restart_i) begin
      low_q       <= '0;
      mid_q       <= '0;
      high_q      <= '0;
      lacc_q      <= '0;
      hacc_q      <= '0;
      load_idx_q  <= '0;
      drain_idx_q <= '0;
      full_q      <= 1'b0;
    end else if (accept_i) begin
      case (kind_o)
        mrdip_pkg::KIND_LOAD: begin
          if (low_wrap) begin
            low_q  <= '0;
            lacc_q <= '0;
            if (mid_wrap) begin
              mid_q <= '0;
              if (high_wrap) begin
                high_q <= '0;
                hacc_q <= '0;
              end else begin
                high_q <= high_q + IW'(1);
                hacc_q <= hacc_q + high_stride_i;
              end
            end else begin
              mid_q <= mid_q + IW'(1);
            end
          end else begin
            low_q  <= low_q + IW'(1);
            lacc_q <= lacc_q + middle_limit_i;
          end
          load_idx_q <= load_next[IW-1:0];
          if (load_last) begin
            full_q      <= 1'b1;
            drain_idx_q <= '0;
          end
        end
        mrdip_pkg::KIND_DRAIN: begin
          if (drain_last) begin
            low_q       <= '0;
            mid_q       <= '0;
            high_q      <= '0;
            lacc_q      <= '0;
            hacc_q      <= '0;
            load_idx_q  <= '0;
            drain_idx_q <= '0;
            full_q      <= 1'b0;
          end else begin
            drain_idx_q <= drain_next[IW-1:0];
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/mrdip_queue.sv */
`default_nettype none
module mrdip_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      data_o,
  output logic                  valid_o,
  output logic                  full_o
);

  localparam int unsigned DEPTH = 2;
  localparam int unsigned PTR_W = $clog2(DEPTH);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [PTR_W:0]   count_q;
  logic             do_pop;

  assign valid_o = (count_q != '0);
  assign full_o  = (count_q == (PTR_W + 1)'(DEPTH));
  assign data_o  = slot_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      case ({push_i, do_pop})
        2'b10:   count_q <= count_q + (PTR_W + 1)'(1);
        2'b01:   count_q <= count_q - (PTR_W + 1)'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/mrdip_back.sv */
`default_nettype none
module mrdip_back #(
  parameter int unsigned MAX_ELEMENTS = 4096,
  parameter int unsigned VALUE_BITS   = 64,
  localparam int unsigned AW = $clog2(MAX_ELEMENTS),
  localparam int unsigned EW = mrdip_pkg::KIND_W + 1 + AW + VALUE_BITS
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           valid_i,
  input  wire logic [EW-1:0]                  entry_i,
  output logic                                result_valid_o,
  output logic [mrdip_pkg::VALUE_W-1:0]       result_value_o,
  output logic                                status_o,
  output logic                                last_word_o
);

  mrdip_pkg::item_kind_e kind, kind_q;
  logic                  last;
  logic [AW-1:0]         addr;
  logic [VALUE_BITS-1:0] value;

  logic [VALUE_BITS-1:0] mem_q [MAX_ELEMENTS];
  logic [VALUE_BITS-1:0] rd_q;
  logic                  valid_q, last_q;

  assign kind  = mrdip_pkg::item_kind_e'(entry_i[EW-1 -: mrdip_pkg::KIND_W]);
  assign last  = entry_i[AW + VALUE_BITS];
  assign addr  = entry_i[AW + VALUE_BITS - 1 -: AW];
  assign value = entry_i[VALUE_BITS-1:0];

  always_ff @(posedge clk_i) begin
    if (valid_i && (kind == mrdip_pkg::KIND_LOAD)) begin
      mem_q[addr] <= value;
    end
    if (valid_i && (kind == mrdip_pkg::KIND_DRAIN)) begin
      rd_q <= mem_q[addr];
    end
    kind_q <= kind;
    last_q <= last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_comb begin
    case (kind_q)
      mrdip_pkg::KIND_LOAD: begin
        result_value_o = '0;
        status_o       = 1'b0;
        last_word_o    = last_q;
      end
      mrdip_pkg::KIND_DRAIN: begin
        result_value_o = mrdip_pkg::VALUE_W'(rd_q);
        status_o       = 1'b0;
        last_word_o    = last_q;
      end
      default: begin
        result_value_o = '0;
        status_o       = 1'b1;
        last_word_o    = 1'b0;
      end
    endcase
  end

  assign result_valid_o = valid_q;

endmodule
`default_nettype wire

/* hw/rtl/mixed_radix_digit_insert_permute_core.sv */
// An accepted item passes the queue and the back end's valid register before
// its result strobe rises. Throughput: one item per cycle while busy_o is low.
// One store write or read per item. A register write re-derives the digit
// strides with one multiply per cycle; busy_o stays high until that finishes.
// Reset (async, rst_ni low): base 2, one digit, position 0, pass restarted;
// store contents are undefined until loaded. The receiver cannot stall results.
`default_nettype none
module mixed_radix_digit_insert_permute_core #(
  parameter int unsigned MAX_ELEMENTS = 4096,
  parameter int unsigned VALUE_BITS   = 64
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start_i,
  output logic                                    busy_o,
  input  wire logic                               opcode_i,
  input  wire logic [mrdip_pkg::VALUE_W-1:0]      element_value_i,
  output logic                                    result_valid_o,
  output logic [mrdip_pkg::VALUE_W-1:0]           result_value_o,
  output logic                                    status_o,
  output logic                                    last_word_o,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [mrdip_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [mrdip_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int unsigned IW = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned AW = $clog2(MAX_ELEMENTS);
  localparam int unsigned EW = mrdip_pkg::KIND_W + 1 + AW + VALUE_BITS;

  logic                         restart, derive_busy, cfg_ok;
  logic [mrdip_pkg::BASE_W-1:0] digit_base;
  logic [IW-1:0]                table_size, middle_limit, high_stride, high_limit;
  logic                         accept;
  mrdip_pkg::item_kind_e        kind;
  logic                         last;
  logic [AW-1:0]                addr;
  logic [VALUE_BITS-1:0]        value;
  logic [EW-1:0]                push_entry, pop_entry;
  logic                         q_valid, q_full;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = derive_busy || q_full;
  assign accept      = start_i && !busy_o;
  assign push_entry  = {kind, last, addr, value};

  mrdip_cfg #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_index_i,
    .cfg_data_i,
    .restart_o      (restart),
    .busy_o         (derive_busy),
    .cfg_ok_o       (cfg_ok),
    .digit_base_o   (digit_base),
    .table_size_o   (table_size),
    .middle_limit_o (middle_limit),
    .high_stride_o  (high_stride),
    .high_limit_o   (high_limit)
  );

  mrdip_front #(
    .MAX_ELEMENTS(MAX_ELEMENTS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_front (
    .clk_i,
    .rst_ni,
    .accept_i       (accept),
    .restart_i      (restart),
    .opcode_i,
    .element_value_i,
    .cfg_ok_i       (cfg_ok),
    .digit_base_i   (digit_base),
    .table_size_i   (table_size),
    .middle_limit_i (middle_limit),
    .high_stride_i  (high_stride),
    .high_limit_i   (high_limit),
    .kind_o         (kind),
    .last_o         (last),
    .addr_o         (addr),
    .value_o        (value)
  );

  mrdip_queue #(
    .WIDTH(EW)
  ) u_queue (
    .clk_i,
    .rst_ni,
    .push_i  (accept),
    .data_i  (push_entry),
    .pop_i   (q_valid),
    .data_o  (pop_entry),
    .valid_o (q_valid),
    .full_o  (q_full)
  );

  mrdip_back #(
    .MAX_ELEMENTS(MAX_ELEMENTS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_back (
    .clk_i,
    .rst_ni,
    .valid_i        (q_valid),
    .entry_i        (pop_entry),
    .result_valid_o,
    .result_value_o,
    .status_o,
    .last_word_o
  );

  a_fixed_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##2 result_valid_o)
    else $error("accepted item did not produce a result two cycles later");

  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(accept, 2))
    else $error("result strobe without a matching accepted item");

  a_cfg_blocks_items: assert property (@(posedge clk_i) disable iff (!rst_ni)
    restart |=> busy_o)
    else $error("register write did not hold off items during derivation");

endmodule
`default_nettype wire
